// ----- rtl/core/itrd_pkg.sv -----
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared types, constants and helpers for the radix digit converter.
// ----------------------------------------------------------------------------
package itrd_pkg;

	localparam int VALUE_BITS = 31;
	localparam int MAX_DIGITS = 32;

	localparam int NUMBER_W = 31;
	localparam int RADIX_W  = 5;
	localparam int CHAR_W   = 7;
	localparam int DIGIT_W  = 4;

	localparam int BIT_CNT_W = $clog2(VALUE_BITS);
	localparam int CNT_W     = $clog2(MAX_DIGITS + 1);

	localparam logic [RADIX_W-1:0] RADIX_MIN  = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX  = 5'd16;
	localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'd48;
	localparam logic [CHAR_W-1:0]  ASCII_A    = 7'd65;
	localparam logic [DIGIT_W-1:0] DEC_LIMIT  = 4'd10;

	typedef struct packed {
		logic [NUMBER_W-1:0] number;
		logic [RADIX_W-1:0]  radix;
	} in_word_t;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic              last;
		logic              bad_radix;
	} out_word_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic div_step;
		logic push;
		logic pop;
		logic err_result;
	} itrd_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic radix_ok;
		logic div_last;
		logic quot_zero;
		logic stack_full;
		logic last_digit;
	} itrd_sts_t;

	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] ch;
		if (d < DEC_LIMIT) begin
			ch = ASCII_ZERO + CHAR_W'(d);
		end else begin
			ch = ASCII_A + CHAR_W'(d - DEC_LIMIT);
		end
		return ch;
	endfunction

endpackage

// ----- rtl/core/integer_to_radix_digits.sv -----
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// Converts a non-negative integer to ASCII digits in radix 2..16.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. The number is divided
// by the radix one quotient bit per cycle, then the remainder is pushed onto
// the digit stack; busy stays high through division and digit emission.
// Digits come out most significant first, one per cycle, each on result for
// exactly one cycle with strobe high; the final one has result.last set.
// There is no backpressure: the receiver must take every strobed word.
// A radix outside 2..16 yields a single word, in the cycle after start, with
// digit_char 0, last 1 and bad_radix 1, and busy never rises for it.
// Zero converts to a single '0'.
// ----------------------------------------------------------------------------
module integer_to_radix_digits (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  itrd_pkg::in_word_t  operand,
	output logic                strobe,
	output itrd_pkg::out_word_t result
);
	import itrd_pkg::*;

	itrd_cmd_t cmd;
	itrd_sts_t sts;

	// sequencer: divide / push loop, then emit
	itrd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// serial divider, digit stack, registered result
	itrd_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.operand (operand),
		.cmd     (cmd),
		.sts     (sts),
		.strobe  (strobe),
		.result  (result)
	);

endmodule

// ----- rtl/core/itrd_datapath.sv -----
// ----------------------------------------------------------------------------
// itrd_datapath
// Bit-serial divider by the radix, LIFO digit stack and output register.
// ----------------------------------------------------------------------------
module itrd_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  itrd_pkg::in_word_t   operand,
	input  itrd_pkg::itrd_cmd_t  cmd,
	output itrd_pkg::itrd_sts_t  sts,
	output logic                 strobe,
	output itrd_pkg::out_word_t  result
);
	import itrd_pkg::*;

	logic [VALUE_BITS-1:0]            quot_q;
	logic [DIGIT_W-1:0]               rem_q;
	logic [RADIX_W-1:0]               radix_q;
	logic [BIT_CNT_W-1:0]             bit_cnt_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic [MAX_DIGITS-1:0][DIGIT_W-1:0] stack_q;
	logic                             strobe_q;
	out_word_t                        out_q;

	logic [RADIX_W-1:0] rem_shift;
	logic               fits;
	logic [RADIX_W-1:0] rem_next;

	// one restoring step: remainder stays below the radix, so 4 bits hold it
	assign rem_shift = {rem_q, quot_q[VALUE_BITS-1]};
	assign fits      = rem_shift >= radix_q;
	assign rem_next  = fits ? rem_shift - radix_q : rem_shift;

	assign sts.radix_ok   = (operand.radix >= RADIX_MIN) && (operand.radix <= RADIX_MAX);
	assign sts.div_last   = bit_cnt_q == BIT_CNT_W'(VALUE_BITS - 1);
	assign sts.quot_zero  = quot_q == '0;
	assign sts.stack_full = cnt_q == CNT_W'(MAX_DIGITS - 1);
	assign sts.last_digit = cnt_q == CNT_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quot_q    <= VALUE_BITS'(operand.number);
			rem_q     <= '0;
			radix_q   <= operand.radix;
			bit_cnt_q <= '0;
		end else if (cmd.div_step) begin
			quot_q    <= {quot_q[VALUE_BITS-2:0], fits};
			rem_q     <= rem_next[DIGIT_W-1:0];
			bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
		end else if (cmd.push) begin
			rem_q     <= '0;
			bit_cnt_q <= '0;
		end
	end

	// stack: push shifts up into entry 0, pop reads entry 0 and shifts down
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			stack_q <= {stack_q[MAX_DIGITS-2:0], rem_q};
		end else if (cmd.pop) begin
			stack_q <= {DIGIT_W'(0), stack_q[MAX_DIGITS-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.push) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (cmd.pop) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.pop || cmd.err_result;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.err_result) begin
			out_q.digit_char <= '0;
			out_q.last       <= 1'b1;
			out_q.bad_radix  <= 1'b1;
		end else if (cmd.pop) begin
			out_q.digit_char <= digit_to_ascii(stack_q[0]);
			out_q.last       <= sts.last_digit;
			out_q.bad_radix  <= 1'b0;
		end
	end

	assign strobe = strobe_q;
	assign result = out_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_DIGITS))
		else $error("digit count past stack depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> cnt_q != '0)
		else $error("pop from empty digit stack");

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && out_q.last && !out_q.bad_radix |-> cnt_q == '0)
		else $error("last digit sent with digits left");

endmodule

// ----- rtl/core/itrd_ctrl.sv -----
// ----------------------------------------------------------------------------
// itrd_ctrl
// Sequencer: divide, push digit, repeat, then pop digits; or flag a bad radix.
// ----------------------------------------------------------------------------
module itrd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  itrd_pkg::itrd_sts_t  sts,
	output itrd_pkg::itrd_cmd_t  cmd,
	output logic                 busy
);
	import itrd_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (sts.radix_ok) begin
						cmd.load = 1'b1;
						state_d  = ST_DIV;
					end else begin
						cmd.err_result = 1'b1;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				cmd.push = 1'b1;
				if (sts.quot_zero || sts.stack_full) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_EMIT: begin
				cmd.pop = 1'b1;
				if (sts.last_digit) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != ST_IDLE;

	a_load_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_DIV)
		else $error("load did not start division");

	a_push_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> $past(state_q) == ST_DIV)
		else $error("push without a finished division");

	a_err_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.err_result |=> state_q == ST_IDLE)
		else $error("bad radix left controller busy");

endmodule

// ----- tb/integer_to_radix_digits_tb.sv -----
// ----------------------------------------------------------------------------
// integer_to_radix_digits_tb
// Checks the radix digit converter against a predictor of its own: every
// accepted word is expanded into the digit words it must produce, and each
// strobed result word is compared field by field with the oldest one
// outstanding. A short directed table runs first, then random words over
// several sender idle phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module integer_to_radix_digits_tb;
	import itrd_pkg::*;

	// directed table row; fixed rows carry a single known result word
	typedef struct packed {
		logic [NUMBER_W-1:0] number;
		logic [RADIX_W-1:0]  radix;
		logic                fixed;
		logic [CHAR_W-1:0]   want_char;
		logic                want_bad;
	} dir_row_t;

	localparam logic [NUMBER_W-1:0] NUMBER_MAX = {NUMBER_W{1'b1}};
	localparam int N_DIRECTED = 23;
	localparam int N_RANDOM_PER_PHASE = 60;
	localparam int DRAIN_CYCLES = 1100;   // one worst-case conversion plus emission

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_word_t  operand;
	logic      strobe;
	out_word_t result;

	out_word_t pending_chars[$];   // result words still owed by the block
	int        err_count;
	int        sender_idle_pct;

	// extremes, every bad radix class, single-digit edges, long conversions
	dir_row_t directed_rows [N_DIRECTED] = '{
		'{31'd0,        5'd10, 1'b1, CHAR_W'("0"), 1'b0},
		'{31'd0,        5'd2,  1'b1, CHAR_W'("0"), 1'b0},
		'{31'd0,        5'd16, 1'b1, CHAR_W'("0"), 1'b0},
		'{31'd0,        5'd0,  1'b1, 7'd0,         1'b1},
		'{31'd5,        5'd1,  1'b1, 7'd0,         1'b1},
		'{NUMBER_MAX,   5'd0,  1'b1, 7'd0,         1'b1},
		'{NUMBER_MAX,   5'd17, 1'b1, 7'd0,         1'b1},
		'{31'd0,        5'd31, 1'b1, 7'd0,         1'b1},
		'{31'd1234,     5'd31, 1'b1, 7'd0,         1'b1},
		'{31'd1,        5'd2,  1'b1, CHAR_W'("1"), 1'b0},
		'{31'd9,        5'd10, 1'b1, CHAR_W'("9"), 1'b0},
		'{31'd10,       5'd16, 1'b1, CHAR_W'("A"), 1'b0},
		'{31'd15,       5'd16, 1'b1, CHAR_W'("F"), 1'b0},
		'{NUMBER_MAX,   5'd2,  1'b0, 7'd0,         1'b0},
		'{NUMBER_MAX,   5'd16, 1'b0, 7'd0,         1'b0},
		'{NUMBER_MAX,   5'd10, 1'b0, 7'd0,         1'b0},
		'{NUMBER_MAX,   5'd3,  1'b0, 7'd0,         1'b0},
		'{NUMBER_MAX,   5'd7,  1'b0, 7'd0,         1'b0},
		'{31'd255,      5'd16, 1'b0, 7'd0,         1'b0},
		'{31'd16,       5'd16, 1'b0, 7'd0,         1'b0},
		'{31'h55555555, 5'd2,  1'b0, 7'd0,         1'b0},
		'{31'h2AAAAAAA, 5'd2,  1'b0, 7'd0,         1'b0},
		'{31'd12345,    5'd15, 1'b0, 7'd0,         1'b0}
	};

	integer_to_radix_digits uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.operand(operand),
		.strobe (strobe),
		.result (result)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Expand one accepted word into the digit words it must produce.
	// Bad radix: one error word. Zero: a single '0'. Otherwise repeated
	// division, remainders collected least significant first, emitted
	// most significant first with last on the final one.
	function automatic void predict_digits(input in_word_t w);
		logic [63:0]       value;
		logic [63:0]       base;
		logic [DIGIT_W-1:0] rems[MAX_DIGITS];
		int                n_digits;
		out_word_t         word;
		begin
			value = 64'(w.number) & ((64'd1 << VALUE_BITS) - 64'd1);
			base  = 64'(w.radix);
			n_digits = 0;
			if (w.radix < RADIX_MIN || w.radix > RADIX_MAX) begin
				word.digit_char = '0;
				word.last       = 1'b1;
				word.bad_radix  = 1'b1;
				pending_chars.push_back(word);
				return;
			end
			if (value == 0) begin
				rems[0]  = '0;
				n_digits = 1;
			end else begin
				while (value != 0 && n_digits < MAX_DIGITS) begin
					rems[n_digits] = DIGIT_W'(value % base);
					value = value / base;
					n_digits++;
				end
			end
			for (int k = n_digits - 1; k >= 0; k--) begin
				if (rems[k] < DEC_LIMIT)
					word.digit_char = ASCII_ZERO + CHAR_W'(rems[k]);
				else
					word.digit_char = ASCII_A + CHAR_W'(rems[k] - DEC_LIMIT);
				word.last      = (k == 0);
				word.bad_radix = 1'b0;
				pending_chars.push_back(word);
			end
		end
	endfunction

	task automatic report_mismatch(input string what);
		begin
			$display("%0t ns: mismatch: %s", $time, what);
			err_count++;
		end
	endtask

	// Present one word, optionally after a random idle gap; hold it until
	// the edge at which busy is low, then book its expected results.
	task automatic issue_word(input in_word_t w, input bit fixed, input out_word_t want);
		begin
			if ($urandom_range(99) < sender_idle_pct) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			start   <= 1'b1;
			operand <= w;
			do @(posedge clk); while (busy !== 1'b0);
			if (fixed)
				pending_chars.push_back(want);
			else
				predict_digits(w);
		end
	endtask

	// Result side: the receiver never stalls, every strobed word is taken.
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && strobe === 1'b1) begin
			if (pending_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected word %p", result));
			end else begin
				want = pending_chars.pop_front();
				if (result.digit_char !== want.digit_char)
					report_mismatch($sformatf("digit_char %h, want %h",
						result.digit_char, want.digit_char));
				if (result.last !== want.last)
					report_mismatch($sformatf("last %b, want %b", result.last, want.last));
				if (result.bad_radix !== want.bad_radix)
					report_mismatch($sformatf("bad_radix %b, want %b",
						result.bad_radix, want.bad_radix));
			end
		end
	end

	// Stimulus: reset, directed table, then random words per idle phase.
	initial begin
		int        phase_idle[4];
		in_word_t  w;
		out_word_t want;
		int        pick;
		logic [63:0] power;
		begin
			phase_idle = '{0, 63, 0, 34};
			err_count = 0;
			sender_idle_pct = 0;
			arst_n  = 1'b0;
			start   = 1'b0;
			operand = '0;
			repeat (6) @(posedge clk);
			arst_n <= 1'b1;

			foreach (directed_rows[i]) begin
				w.number = directed_rows[i].number;
				w.radix  = directed_rows[i].radix;
				want.digit_char = directed_rows[i].want_char;
				want.last       = 1'b1;
				want.bad_radix  = directed_rows[i].want_bad;
				issue_word(w, directed_rows[i].fixed, want);
			end

			foreach (phase_idle[p]) begin
				sender_idle_pct = phase_idle[p];
				repeat (N_RANDOM_PER_PHASE) begin
					// mostly valid radixes; invalid ones cover 0, 1 and 17..31
					if ($urandom_range(99) < 12) begin
						pick = $urandom_range(0, 16);
						w.radix = (pick < 2) ? RADIX_W'(pick) : RADIX_W'(pick + 15);
					end else begin
						w.radix = RADIX_W'($urandom_range(2, 16));
					end
					pick = $urandom_range(0, 9);
					if (pick == 0) begin
						w.number = '0;
					end else if (pick <= 2) begin
						w.number = NUMBER_W'($urandom_range(1, 255));
					end else if (pick == 3 && w.radix >= RADIX_MIN && w.radix <= RADIX_MAX) begin
						// digit-count boundary: a power of the radix or one below it
						power = 1;
						repeat ($urandom_range(1, 30))
							if (power * w.radix <= 64'(NUMBER_MAX))
								power = power * w.radix;
						w.number = NUMBER_W'(power - 64'($urandom_range(0, 1)));
					end else if (pick <= 6) begin
						w.number = NUMBER_W'($urandom());
					end else begin
						w.number = NUMBER_W'($urandom() >> $urandom_range(0, 30));
					end
					issue_word(w, 1'b0, want);
				end
			end
			start <= 1'b0;

			while (pending_chars.size() != 0) @(posedge clk);
			repeat (DRAIN_CYCLES) @(posedge clk);
			if (err_count == 0)
				$display("[integer_to_radix_digits] OK");
			else
				$display("[integer_to_radix_digits] ERROR");
			$finish;
		end
	end

	// Watchdog: several times the slowest legal run.
	initial begin
		#4_000_000;
		$display("[integer_to_radix_digits] ERROR");
		$finish;
	end

endmodule
